/* design/signed_decimal_frame_sender_defines.svh */
// Assertion macros used by the checker file.
`ifndef SIGNED_DECIMAL_FRAME_SENDER_DEFINES_SVH
`define SIGNED_DECIMAL_FRAME_SENDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDFS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDFS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sdfs_pkg.sv */
`default_nettype none
package sdfs_pkg;

  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned DIGIT_CNT_W = 4;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = 1;
  localparam int unsigned Q_CNT_W     = 2;

  localparam logic [7:0]  TERM_BYTE   = 8'd200;
  localparam logic [7:0]  ASCII_ZERO  = 8'd48;
  localparam logic [7:0]  MINUS_SIGN  = 8'd45;
  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         header_byte;
    logic               framed;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0]                      header_byte;
    logic                            framed;
    logic                            negative;
    logic [MAX_DIGITS-1:0][3:0]      digits;
    logic [DIGIT_CNT_W-1:0]          nd;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEAD,
    B_SIGN,
    B_DIGIT,
    B_TERM
  } back_state_e;

endpackage
`default_nettype wire

/* design/sdfs_front.sv */
`default_nettype none
module sdfs_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire sdfs_pkg::in_t item_i,
  input  wire logic         q_full_i,
  output logic              push_o,
  output sdfs_pkg::job_t    job_o
);

  sdfs_pkg::front_state_e state_q, state_d;

  logic [31:0]                          mag_q, mag_d;
  logic [63:0]                          prod_q;
  logic [7:0]                           header_q;
  logic                                 framed_q;
  logic                                 neg_q;
  logic [sdfs_pkg::MAX_DIGITS-1:0][3:0] digits_q;
  logic [sdfs_pkg::DIGIT_CNT_W-1:0]     nd_q;

  logic        accept;
  logic [28:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;

  assign accept   = (state_q == sdfs_pkg::F_IDLE) && start;
  assign quot     = prod_q[63:sdfs_pkg::RECIP_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = mag_q - quot_x10;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdfs_pkg::F_IDLE: if (start) state_d = sdfs_pkg::F_MUL;
      sdfs_pkg::F_MUL:  state_d = sdfs_pkg::F_DIV;
      sdfs_pkg::F_DIV:  state_d = (quot == '0) ? sdfs_pkg::F_PUSH : sdfs_pkg::F_MUL;
      sdfs_pkg::F_PUSH: if (!q_full_i) state_d = sdfs_pkg::F_IDLE;
      default:          state_d = sdfs_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state_q != sdfs_pkg::F_IDLE);
    push_o = (state_q == sdfs_pkg::F_PUSH) && !q_full_i;
    job_o.header_byte = header_q;
    job_o.framed      = framed_q;
    job_o.negative    = neg_q;
    job_o.digits      = digits_q;
    job_o.nd          = nd_q;
  end

  // magnitude in unsigned arithmetic: the most negative value stays exact
  always_comb begin
    mag_d = mag_q;
    if (accept) begin
      mag_d = item_i.value[31] ? (32'd0 - item_i.value) : item_i.value;
    end else if (state_q == sdfs_pkg::F_DIV) begin
      mag_d = {3'b000, quot};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdfs_pkg::F_IDLE;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        nd_q <= '0;
      end else if (state_q == sdfs_pkg::F_DIV) begin
        nd_q <= nd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (accept) begin
      header_q <= item_i.header_byte;
      framed_q <= item_i.framed;
      neg_q    <= item_i.value[31];
    end
    if (state_q == sdfs_pkg::F_MUL) begin
      prod_q <= mag_q * sdfs_pkg::RECIP_TEN;
    end
    if (state_q == sdfs_pkg::F_DIV) begin
      digits_q[nd_q] <= rem_full[3:0];
    end
  end

endmodule
`default_nettype wire

/* design/sdfs_queue.sv */
`default_nettype none
module sdfs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sdfs_pkg::job_t push_job_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                empty_o,
  output sdfs_pkg::job_t      head_o
);

  sdfs_pkg::job_t entries_q [sdfs_pkg::Q_DEPTH];

  logic [sdfs_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [sdfs_pkg::Q_CNT_W-1:0] count_q;

  localparam logic [sdfs_pkg::Q_PTR_W-1:0] LastPtr = sdfs_pkg::Q_PTR_W'(sdfs_pkg::Q_DEPTH - 1);
  localparam logic [sdfs_pkg::Q_CNT_W-1:0] FullCnt = sdfs_pkg::Q_CNT_W'(sdfs_pkg::Q_DEPTH);

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

/* design/sdfs_back.sv */
`default_nettype none
module sdfs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire sdfs_pkg::job_t head_i,
  output logic                pop_o,
  output logic                strobe_o,
  output sdfs_pkg::out_t      result_o
);

  sdfs_pkg::back_state_e state_q, state_d;

  sdfs_pkg::job_t                   job_q;
  logic [sdfs_pkg::DIGIT_CNT_W-1:0] idx_q;
  sdfs_pkg::out_t                   res_q, res_d;
  logic                             strobe_q, strobe_d;

  assign pop_o    = (state_q == sdfs_pkg::B_IDLE) && !q_empty_i;
  assign strobe_o = strobe_q;
  assign result_o = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdfs_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          if (head_i.framed)        state_d = sdfs_pkg::B_HEAD;
          else if (head_i.negative) state_d = sdfs_pkg::B_SIGN;
          else                      state_d = sdfs_pkg::B_DIGIT;
        end
      end
      sdfs_pkg::B_HEAD:  state_d = job_q.negative ? sdfs_pkg::B_SIGN : sdfs_pkg::B_DIGIT;
      sdfs_pkg::B_SIGN:  state_d = sdfs_pkg::B_DIGIT;
      sdfs_pkg::B_DIGIT: begin
        if (idx_q == '0) begin
          state_d = job_q.framed ? sdfs_pkg::B_TERM : sdfs_pkg::B_IDLE;
        end
      end
      sdfs_pkg::B_TERM:  state_d = sdfs_pkg::B_IDLE;
      default:           state_d = sdfs_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    strobe_d      = 1'b1;
    res_d.out_byte = '0;
    res_d.last     = 1'b0;
    case (state_q)
      sdfs_pkg::B_IDLE:  strobe_d = 1'b0;
      sdfs_pkg::B_HEAD:  res_d.out_byte = job_q.header_byte;
      sdfs_pkg::B_SIGN:  res_d.out_byte = sdfs_pkg::MINUS_SIGN;
      sdfs_pkg::B_DIGIT: begin
        res_d.out_byte = sdfs_pkg::ASCII_ZERO + {4'h0, job_q.digits[idx_q]};
        res_d.last     = (idx_q == '0) && !job_q.framed;
      end
      sdfs_pkg::B_TERM: begin
        res_d.out_byte = sdfs_pkg::TERM_BYTE;
        res_d.last     = 1'b1;
      end
      default:           strobe_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sdfs_pkg::B_IDLE;
      strobe_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (pop_o) begin
        idx_q <= head_i.nd - 1'b1;
      end else if (state_q == sdfs_pkg::B_DIGIT && idx_q != '0) begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      job_q <= head_i;
    end
  end

endmodule
`default_nettype wire

/* design/signed_decimal_frame_sender.sv */
// Signed decimal frame sender. Present a word on item_i with start high;
// it is taken at the rising edge where start is high and busy is low. The
// block answers with a run of bytes on result_o, one per strobe_o cycle,
// most significant digit first: header byte (framed only), '-' for a
// negative value, the ASCII digits with no leading zeros (a lone '0' for
// zero), then terminator 200 (framed only); result_o.last marks the final
// byte. -2147483648 prints in full. The receiver cannot stall: every
// strobe_o cycle is a delivered byte, so it must take one byte per cycle.
// The converter peels one digit per multiply and divide step (F_MUL,
// then F_DIV) with a 32x32 reciprocal multiply by ten, for 1..10 digits;
// busy stays high from the accepting edge until the run is pushed, and
// no new word is taken before then. The converted run waits in a two-entry
// queue; the byte sender emits one byte per cycle (1..13 bytes) and
// returns to idle between runs. busy also stays high while a finished
// conversion waits for a queue slot.
`default_nettype none
module signed_decimal_frame_sender (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire sdfs_pkg::in_t  item_i,
  output logic                strobe_o,
  output sdfs_pkg::out_t      result_o
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  sdfs_pkg::job_t push_job;
  sdfs_pkg::job_t head_job;

  // Front: accept the word, split the magnitude into decimal digits.
  sdfs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Hold converted runs so conversion and sending proceed on their own.
  sdfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  // Back: serialize header, sign, digits and terminator, one byte a cycle.
  sdfs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .head_i    (head_job),
    .pop_o     (pop),
    .strobe_o  (strobe_o),
    .result_o  (result_o)
  );

endmodule
`default_nettype wire

/* design/sdfs_checker.sv */
`default_nettype none
`include "signed_decimal_frame_sender_defines.svh"
module sdfs_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           strobe_i,
  input wire sdfs_pkg::out_t result_i
);

  // An accepted word always occupies the converter for the next cycle.
  `SDFS_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "busy missing after accept")

  // busy rises only because a word was accepted.
  `SDFS_ASSERT_IMP(a_busy_cause, clk_i, rst_ni, $rose(busy), $past(start), "busy rose without start")

  // A run's last byte is never followed directly by another strobe.
  `SDFS_ASSERT_NXT(a_run_gap, clk_i, rst_ni, strobe_i && result_i.last, !strobe_i, "no gap after last byte")

endmodule

bind signed_decimal_frame_sender sdfs_checker u_sdfs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_i (strobe_o),
  .result_i (result_o)
);
`default_nettype wire
